/* hdl/lead_compensator_hbridge_drive_assert.svh */
// Assertion macros for the H-bridge lead compensator checker.
// Used by lch_checker.sv; no other dependencies.
`ifndef LEAD_COMPENSATOR_HBRIDGE_DRIVE_ASSERT_SVH
`define LEAD_COMPENSATOR_HBRIDGE_DRIVE_ASSERT_SVH

// same-cycle implication, disabled during reset
`define LCH_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lch check failed");

// next-cycle implication, disabled during reset
`define LCH_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lch check failed");

`endif

/* hdl/lch_pkg.sv */
// Shared types and constants of the H-bridge lead compensator.
// No dependencies.
package lch_pkg;

    localparam logic signed [18:0] COEF_A = 19'sd152470;
    localparam logic signed [18:0] COEF_B = 19'sd145926;
    localparam logic signed [12:0] COEF_G = 13'sd3686;

    localparam logic signed [35:0] Y_MAX = {1'b0, {35{1'b1}}};
    localparam logic signed [35:0] Y_MIN = {1'b1, {35{1'b0}}};

    localparam logic              MODE_RST       = 1'b1;
    localparam logic [11:0]       VREF_RST       = 12'd1524;
    localparam logic [11:0]       TRIP_HIGH_RST  = 12'd950;
    localparam logic signed [12:0] TRIP_LOW_RST  = -13'sd700;
    localparam logic [9:0]        DUTY_LIMIT_RST = 10'd408;

    typedef enum logic [2:0] {
        CFG_MODE       = 3'd0,
        CFG_VREF       = 3'd1,
        CFG_TRIP_HIGH  = 3'd2,
        CFG_TRIP_LOW   = 3'd3,
        CFG_DUTY_LIMIT = 3'd4
    } cfg_idx_t;

    typedef struct packed {
        logic               mode_digital;
        logic [11:0]        vref;
        logic [11:0]        trip_high;
        logic signed [12:0] trip_low;
        logic [9:0]         duty_limit;
    } cfg_t;

    typedef struct packed {
        logic signed [12:0] err;
        logic               trip;
        logic signed [31:0] ff;
    } front_t;

    typedef struct packed {
        logic [9:0] duty;
        logic       dir_forward;
        logic       dir_reverse;
        logic       tripped;
    } result_t;

endpackage

/* hdl/lch_front.sv */
// Error, trip window and feed-forward terms (A*e - B*e_prev), registered.
// Depends on lch_pkg.
module lch_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           load,
    input  logic [11:0]    sample,
    input  lch_pkg::cfg_t  cfg,
    output lch_pkg::front_t front
);
    import lch_pkg::*;

    logic signed [12:0] err;
    logic               trip;
    logic signed [31:0] prod_a;
    logic signed [31:0] prod_b;
    logic signed [31:0] ff;
    logic signed [12:0] prev_error_reg;
    front_t             front_reg;

    assign err    = $signed({1'b0, cfg.vref}) - $signed({1'b0, sample});
    assign trip   = ($signed({err[12], err}) > $signed({2'b00, cfg.trip_high}))
                 || (err < cfg.trip_low);
    assign prod_a = 32'(err) * 32'(COEF_A);
    assign prod_b = 32'(prev_error_reg) * 32'(COEF_B);
    assign ff     = prod_a - prod_b;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_error_reg <= '0;
        end
        else if (load && cfg.mode_digital)
        begin
            prev_error_reg <= err;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            front_reg.err  <= err;
            front_reg.trip <= trip;
            front_reg.ff   <= ff;
        end
    end

    assign front = front_reg;

endmodule

/* hdl/lch_loop.sv */
// Compensator feedback (0.9 * y_prev), saturation, duty and direction logic.
// Depends on lch_pkg.
module lch_loop (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  lch_pkg::front_t  front,
    input  lch_pkg::cfg_t    cfg,
    output lch_pkg::result_t result
);
    import lch_pkg::*;

    logic signed [35:0] y_prev_reg;
    logic               fwd_reg;
    logic               rev_reg;
    result_t            result_reg;

    logic signed [48:0] fb_prod;
    logic signed [48:0] fb_rnd;
    logic signed [36:0] fb;
    logic signed [37:0] y_sum;
    logic signed [35:0] y;
    logic [35:0]        y_mag;
    logic [23:0]        whole;
    logic [12:0]        e_mag;
    logic [9:0]         duty_d;
    logic [9:0]         duty_p;
    logic [9:0]         duty_sel;
    logic               neg_sel;
    logic               fwd_next;
    logic               rev_next;

    assign fb_prod = 49'(y_prev_reg) * 49'(COEF_G);
    assign fb_rnd  = fb_prod + 49'sd2048;
    assign fb      = $signed(fb_rnd[48:12]);
    assign y_sum   = $signed({{6{front.ff[31]}}, front.ff}) + $signed({fb[36], fb});

    always_comb
    begin
        if ((y_sum[37:35] == 3'b000) || (y_sum[37:35] == 3'b111))
        begin
            y = y_sum[35:0];
        end
        else if (y_sum[37])
        begin
            y = Y_MIN;
        end
        else
        begin
            y = Y_MAX;
        end
    end

    assign y_mag  = y[35] ? (~y + 36'd1) : y;
    assign whole  = y_mag[35:12];
    assign duty_d = (whole > {14'd0, cfg.duty_limit}) ? cfg.duty_limit : whole[9:0];

    assign e_mag  = front.err[12] ? (~front.err + 13'd1) : front.err;
    assign duty_p = (e_mag > {3'd0, cfg.duty_limit}) ? cfg.duty_limit : e_mag[9:0];

    always_comb
    begin
        if (cfg.mode_digital)
        begin
            duty_sel = duty_d;
            neg_sel  = y[35];
        end
        else
        begin
            duty_sel = duty_p;
            // a zero limit clamps a negative error to zero, which counts as forward
            neg_sel  = front.err[12] && (cfg.duty_limit != 10'd0);
        end
    end

    assign fwd_next = front.trip ? fwd_reg : !neg_sel;
    assign rev_next = front.trip ? rev_reg : neg_sel;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            y_prev_reg <= '0;
            fwd_reg    <= 1'b0;
            rev_reg    <= 1'b0;
        end
        else if (load)
        begin
            fwd_reg <= fwd_next;
            rev_reg <= rev_next;
            if (cfg.mode_digital)
            begin
                y_prev_reg <= y;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg.duty        <= front.trip ? 10'd0 : duty_sel;
            result_reg.dir_forward <= fwd_next;
            result_reg.dir_reverse <= rev_next;
            result_reg.tripped     <= front.trip;
        end
    end

    assign result = result_reg;

endmodule

/* hdl/lead_compensator_hbridge_drive.sv */
// Top level: sample and result channels, configuration registers, pipeline control.
// Depends on lch_pkg, lch_front, lch_loop.
//
//  channel   signals                               width
//  input     in_valid, in_ready, adc_sample        12
//  output    out_valid, out_ready, duty,           10, 1, 1, 1
//            dir_forward, dir_reverse, tripped
//  config    cfg_wr_en, cfg_addr, cfg_wdata        3, 13
//
// One sample per cycle sustained while the output is not stalled; out_valid rises
// once the sample has passed the three register stages: input sample, feed-forward
// products, result. The y feedback loop (36x13 multiply, add, saturate) sets the rate.
// Reset clears valids, config to defaults and compensator state to zero.
// A stalled output backs up the stages; each stage still takes data while free.
module lead_compensator_hbridge_drive (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [11:0] adc_sample,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [9:0]  duty,
    output logic        dir_forward,
    output logic        dir_reverse,
    output logic        tripped,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_addr,
    input  logic [12:0] cfg_wdata
);
    import lch_pkg::*;

    cfg_t        cfg_reg;
    cfg_t        cfg_next;
    logic        s1_valid_reg;
    logic [11:0] sample_reg;
    logic        s2_valid_reg;
    logic        out_valid_reg;

    logic        out_free;
    logic        s2_free;
    logic        s1_free;
    logic        s1_adv;
    logic        s2_adv;
    logic        in_transfer;
    front_t      front;
    result_t     result;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            case (cfg_idx_t'(cfg_addr))
                CFG_MODE:       cfg_next.mode_digital = cfg_wdata[0];
                CFG_VREF:       cfg_next.vref         = cfg_wdata[11:0];
                CFG_TRIP_HIGH:  cfg_next.trip_high    = cfg_wdata[11:0];
                CFG_TRIP_LOW:   cfg_next.trip_low     = $signed(cfg_wdata);
                CFG_DUTY_LIMIT: cfg_next.duty_limit   = cfg_wdata[9:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    assign out_free    = !out_valid_reg || out_ready;
    assign s2_adv      = s2_valid_reg && out_free;
    assign s2_free     = !s2_valid_reg || out_free;
    assign s1_adv      = s1_valid_reg && s2_free;
    assign s1_free     = !s1_valid_reg || s2_free;
    assign in_ready    = s1_free;
    assign in_transfer = in_valid && s1_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode_digital <= MODE_RST;
            cfg_reg.vref         <= VREF_RST;
            cfg_reg.trip_high    <= TRIP_HIGH_RST;
            cfg_reg.trip_low     <= TRIP_LOW_RST;
            cfg_reg.duty_limit   <= DUTY_LIMIT_RST;
            s1_valid_reg         <= 1'b0;
            s2_valid_reg         <= 1'b0;
            out_valid_reg        <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
            if (in_transfer)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_adv)
            begin
                s2_valid_reg <= 1'b1;
            end
            else if (s2_adv)
            begin
                s2_valid_reg <= 1'b0;
            end
            if (s2_adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_transfer)
        begin
            sample_reg <= adc_sample;
        end
    end

    lch_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (s1_adv),
        .sample (sample_reg),
        .cfg    (cfg_reg),
        .front  (front)
    );

    lch_loop u_loop (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (s2_adv),
        .front  (front),
        .cfg    (cfg_reg),
        .result (result)
    );

    assign out_valid   = out_valid_reg;
    assign duty        = result.duty;
    assign dir_forward = result.dir_forward;
    assign dir_reverse = result.dir_reverse;
    assign tripped     = result.tripped;

endmodule

/* hdl/lch_checker.sv */
// Port-level checks of the H-bridge lead compensator, bound to the top level.
// Depends on lead_compensator_hbridge_drive_assert.svh.
`include "lead_compensator_hbridge_drive_assert.svh"

module lch_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [9:0]  duty,
    input logic        dir_forward,
    input logic        dir_reverse,
    input logic        tripped
);

    `LCH_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(duty) && $stable(dir_forward) && $stable(dir_reverse) && $stable(tripped))
    `LCH_ASSERT_IMP(a_trip_zero, clk, rst_n, out_valid && tripped, duty == 10'd0)
    `LCH_ASSERT_IMP(a_dir_excl, clk, rst_n, out_valid, !(dir_forward && dir_reverse))
    `LCH_ASSERT_IMP(a_dir_set, clk, rst_n, out_valid && !tripped, dir_forward != dir_reverse)

endmodule

bind lead_compensator_hbridge_drive lch_checker u_lch_checker (.*);

/* verif/lch_drive_checker.sv */
`timescale 1ns / 100ps
// Checker for the lead-compensated H-bridge drive: predicts and scores every result transfer.
// Depends on lch_pkg; watches the sample, result and config ports of the block.
module lch_drive_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [11:0] adc_sample,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [9:0]  duty,
    input  logic        dir_forward,
    input  logic        dir_reverse,
    input  logic        tripped,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_addr,
    input  logic [12:0] cfg_wdata,
    output int          mismatch_count,
    output int          outstanding
);
    import lch_pkg::*;

    localparam longint LEAD_GAIN = 152470;
    localparam longint LAG_GAIN  = 145926;
    localparam longint POLE_GAIN = 3686;
    localparam longint DRIVE_MAX = 64'sd34359738367;
    localparam longint DRIVE_MIN = -64'sd34359738368;

    logic               mode_dig;
    logic [11:0]        vref_c;
    logic [11:0]        trip_hi_c;
    logic signed [12:0] trip_lo_c;
    logic [9:0]         lim_c;

    longint             err_hist;
    longint             drive_hist;
    logic               fwd_q;
    logic               rev_q;

    result_t            drive_expected_q[$];
    int                 result_idx;

    task automatic report_mismatch(input string msg);
        $display("ERROR: result %0d: %s", result_idx, msg);
        mismatch_count++;
    endtask

    task automatic step_drive(input logic [11:0] sample, output result_t r);
        longint e;
        longint lo_thr;
        longint y;
        longint mag;
        longint whole;
        longint lim;
        logic   trip;
        logic   neg;
        e      = longint'(vref_c) - longint'(sample);
        lo_thr = trip_lo_c;
        lim    = lim_c;
        trip   = (e > longint'(trip_hi_c)) || (e < lo_thr);
        neg    = 1'b0;
        whole  = 0;
        if (mode_dig)
        begin
            y = LEAD_GAIN * e - LAG_GAIN * err_hist
                + ((POLE_GAIN * drive_hist + 64'sd2048) >>> 12);
            if (y > DRIVE_MAX)
                y = DRIVE_MAX;
            if (y < DRIVE_MIN)
                y = DRIVE_MIN;
            err_hist   = e;
            drive_hist = y;
            if (!trip)
            begin
                neg   = (y < 0);
                mag   = neg ? -y : y;
                whole = mag >>> 12;
                if (whole > lim)
                    whole = lim;
            end
        end
        else if (!trip)
        begin
            if (e > lim)
                e = lim;
            if (e < -lim)
                e = -lim;
            neg   = (e < 0);
            whole = neg ? -e : e;
        end
        if (!trip)
        begin
            fwd_q = !neg;
            rev_q = neg;
        end
        else
            whole = 0;
        r.duty        = 10'(whole);
        r.dir_forward = fwd_q;
        r.dir_reverse = rev_q;
        r.tripped     = trip;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        result_t got;
        result_t want;
        result_t next_r;
        if (!rst_n)
        begin
            mode_dig   = MODE_RST;
            vref_c     = VREF_RST;
            trip_hi_c  = TRIP_HIGH_RST;
            trip_lo_c  = TRIP_LOW_RST;
            lim_c      = DUTY_LIMIT_RST;
            err_hist   = 0;
            drive_hist = 0;
            fwd_q      = 1'b0;
            rev_q      = 1'b0;
            drive_expected_q.delete();
            outstanding    = 0;
            mismatch_count = 0;
            result_idx     = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                got = '{duty, dir_forward, dir_reverse, tripped};
                if (drive_expected_q.size() == 0)
                    report_mismatch("result transfer with nothing expected");
                else
                begin
                    want = drive_expected_q.pop_front();
                    if (got.duty !== want.duty)
                        report_mismatch($sformatf("duty %0d, expected %0d",
                                                  got.duty, want.duty));
                    if (got.dir_forward !== want.dir_forward)
                        report_mismatch($sformatf("dir_forward %0b, expected %0b",
                                                  got.dir_forward, want.dir_forward));
                    if (got.dir_reverse !== want.dir_reverse)
                        report_mismatch($sformatf("dir_reverse %0b, expected %0b",
                                                  got.dir_reverse, want.dir_reverse));
                    if (got.tripped !== want.tripped)
                        report_mismatch($sformatf("tripped %0b, expected %0b",
                                                  got.tripped, want.tripped));
                end
                result_idx++;
            end
            if (in_valid && in_ready)
            begin
                step_drive(adc_sample, next_r);
                drive_expected_q.push_back(next_r);
            end
            if (cfg_wr_en)
            begin
                case (cfg_addr)
                    CFG_MODE:       mode_dig  = cfg_wdata[0];
                    CFG_VREF:       vref_c    = cfg_wdata[11:0];
                    CFG_TRIP_HIGH:  trip_hi_c = cfg_wdata[11:0];
                    CFG_TRIP_LOW:   trip_lo_c = cfg_wdata;
                    CFG_DUTY_LIMIT: lim_c     = cfg_wdata[9:0];
                    default: ;
                endcase
            end
            outstanding = drive_expected_q.size();
        end
    end

endmodule

/* verif/lead_compensator_hbridge_drive_tb.sv */
`timescale 1ns / 100ps
// Top of the H-bridge drive testbench: clock, reset, sample and config stimulus, verdict.
// Depends on lch_pkg, lead_compensator_hbridge_drive and lch_drive_checker.
module lead_compensator_hbridge_drive_tb;
    import lch_pkg::*;

    localparam int          NUM_PHASES      = 12;
    localparam int          PHASE_ITEMS     = 161;
    localparam int          SETTLE_CYCLES   = 8;
    localparam int          LIMIT_CYCLES    = 400000;
    localparam logic [2:0]  CFG_SPARE_FIRST = 3'd5;
    localparam logic [2:0]  CFG_SPARE_LAST  = 3'd7;
    localparam logic [12:0] TRIP_LOW_MIN    = 13'h1000;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [11:0] adc_sample;
    logic        out_valid;
    logic        out_ready;
    logic [9:0]  duty;
    logic        dir_forward;
    logic        dir_reverse;
    logic        tripped;
    logic        cfg_wr_en;
    logic [2:0]  cfg_addr;
    logic [12:0] cfg_wdata;

    int          mismatches;
    int          outstanding;
    int          cycle_count = 0;
    int          hold_cnt;
    logic        in_fire;
    logic        idle_on;
    logic [11:0] vref_now;

    lead_compensator_hbridge_drive uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .adc_sample  (adc_sample),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .duty        (duty),
        .dir_forward (dir_forward),
        .dir_reverse (dir_reverse),
        .tripped     (tripped),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata)
    );

    lch_drive_checker checker_i (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .adc_sample     (adc_sample),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .duty           (duty),
        .dir_forward    (dir_forward),
        .dir_reverse    (dir_reverse),
        .tripped        (tripped),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_addr       (cfg_addr),
        .cfg_wdata      (cfg_wdata),
        .mismatch_count (mismatches),
        .outstanding    (outstanding)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        in_fire <= in_valid && in_ready;
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // result side backpressure in bursts
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!idle_on)
            begin
                hold_cnt  = 0;
                out_ready = 1'b1;
            end
            else if (hold_cnt > 0)
            begin
                hold_cnt--;
                out_ready = 1'b0;
            end
            else if ($urandom_range(0, 9) == 0)
            begin
                hold_cnt  = $urandom_range(1, 15) - 1;
                out_ready = 1'b0;
            end
            else
                out_ready = 1'b1;
        end
        else
        begin
            hold_cnt  = 0;
            out_ready = 1'b0;
        end
    end

    task automatic send_sample(input logic [11:0] v);
        int gap;
        if (idle_on && $urandom_range(0, 7) == 0)
        begin
            gap      = $urandom_range(1, 15);
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid   = 1'b1;
        adc_sample = v;
        do
            @(negedge clk);
        while (!in_fire);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [12:0] data);
        cfg_wr_en = 1'b1;
        cfg_addr  = idx;
        cfg_wdata = data;
        @(negedge clk);
        cfg_wr_en = 1'b0;
    endtask

    // hold off until every sample transfer has its result
    task automatic settle();
        in_valid = 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic pick_settings();
        logic [11:0] th;
        logic [12:0] tl;
        logic [9:0]  lim;
        case ($urandom_range(0, 3))
            0:       vref_now = 12'd0;
            1:       vref_now = 12'hFFF;
            default: vref_now = 12'($urandom);
        endcase
        case ($urandom_range(0, 3))
            0:       th = 12'hFFF;
            1:       th = 12'd0;
            default: th = 12'($urandom);
        endcase
        case ($urandom_range(0, 5))
            0:       tl = TRIP_LOW_MIN;
            1:       tl = 13'd0;
            2:       tl = 13'($urandom);
            default: tl = 13'(-int'($urandom_range(0, 4096)));
        endcase
        case ($urandom_range(0, 3))
            0:       lim = 10'd0;
            1:       lim = 10'h3FF;
            default: lim = 10'($urandom);
        endcase
        write_reg(CFG_MODE, {12'($urandom), 1'($urandom)});
        write_reg(CFG_VREF, {1'($urandom), vref_now});
        write_reg(CFG_TRIP_HIGH, {1'($urandom), th});
        write_reg(CFG_TRIP_LOW, tl);
        write_reg(CFG_DUTY_LIMIT, {3'($urandom), lim});
        if ($urandom_range(0, 2) == 0)
            write_reg(3'($urandom_range(CFG_SPARE_FIRST, CFG_SPARE_LAST)), 13'($urandom));
    endtask

    // mostly samples near vref so the trip window is exercised from inside
    function automatic logic [11:0] pick_sample();
        int span;
        int s;
        if ($urandom_range(0, 3) == 0)
            return 12'($urandom);
        case ($urandom_range(0, 2))
            0:       span = 4;
            1:       span = 64;
            default: span = 1024;
        endcase
        s = int'(vref_now) - span + int'($urandom_range(0, 2 * span));
        if (s < 0)
            s = 0;
        if (s > 4095)
            s = 4095;
        return 12'(s);
    endfunction

    initial
    begin
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        adc_sample  = 12'd0;
        cfg_wr_en   = 1'b0;
        cfg_addr    = 3'd0;
        cfg_wdata   = 13'd0;
        idle_on     = 1'b1;
        vref_now    = VREF_RST;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // reset settings, digital mode: window edges and both rails
        send_sample(12'd1524);
        send_sample(12'd0);
        send_sample(12'hFFF);
        send_sample(12'd574);
        send_sample(12'd573);
        send_sample(12'd2224);
        send_sample(12'd2225);
        send_sample(12'd1530);
        send_sample(12'd1520);

        // proportional drive: clamp, reverse, held direction on trip
        settle();
        write_reg(CFG_MODE, 13'd0);
        send_sample(12'd1116);
        send_sample(12'd1000);
        send_sample(12'd1525);
        send_sample(12'd2225);
        send_sample(12'd1524);
        send_sample(12'd573);

        // widest window, limit extremes
        settle();
        write_reg(CFG_VREF, 13'hFFF);
        write_reg(CFG_TRIP_HIGH, 13'hFFF);
        write_reg(CFG_TRIP_LOW, TRIP_LOW_MIN);
        write_reg(CFG_DUTY_LIMIT, 13'h3FF);
        send_sample(12'd0);
        send_sample(12'hFFF);
        settle();
        write_reg(CFG_MODE, 13'd1);
        write_reg(CFG_VREF, 13'd0);
        write_reg(CFG_DUTY_LIMIT, 13'd0);
        send_sample(12'hFFF);
        send_sample(12'd0);
        send_sample(12'd1);

        // positive trip_low: empty window trips every tick
        settle();
        write_reg(CFG_TRIP_LOW, 13'd100);
        write_reg(CFG_TRIP_HIGH, 13'd50);
        write_reg(CFG_VREF, 13'd2000);
        send_sample(12'd1925);
        send_sample(12'd4000);

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            settle();
            pick_settings();
            idle_on = (p == NUM_PHASES - 1) ? 1'b0 : ($urandom_range(0, 4) != 0);
            for (int i = 0; i < PHASE_ITEMS; i++)
                send_sample(pick_sample());
        end

        settle();
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
